@@ rtl/mvma_pkg.sv @@
package mvma_pkg;

   localparam int DATA_W       = 32;
   localparam int ACC_W        = 64;
   localparam int IDX_W        = 6;
   localparam int CNT_W        = 7;
   localparam int OP_W         = 2;
   localparam int CSR_ADDR_W   = 5;
   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;
   localparam int RESULT_LIMIT = 64;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_MATRIX = 2'd0,
      OP_LOAD_VECTOR = 2'd1,
      OP_LOAD_PRIOR  = 2'd2,
      OP_COMPUTE     = 2'd3
   } op_type;

   localparam logic [2:0] REG_ALPHA     = 3'd0;
   localparam logic [2:0] REG_BETA      = 3'd1;
   localparam logic [2:0] REG_NUM_ROWS  = 3'd2;
   localparam logic [2:0] REG_NUM_COLS  = 3'd3;
   localparam logic [2:0] REG_TRANSPOSE = 3'd4;

   localparam logic signed [DATA_W-1:0] ALPHA_RESET = 32'sd65536;
   localparam logic signed [ACC_W-1:0]  ROUND_HALF  = 64'sd32768;

   typedef struct packed {
      logic signed [DATA_W-1:0] alpha;
      logic signed [DATA_W-1:0] beta;
   } scale_cfg_type;

   // saturating signed 64-bit add
   function automatic logic signed [ACC_W-1:0] sat_add64(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         sat_add64 = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         sat_add64 = s[ACC_W-1:0];
      end
   endfunction

   // q32.32 to q16.16, round half up, saturate
   function automatic logic signed [DATA_W-1:0] round_q16(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] y;
      y = sat_add64(x, ROUND_HALF);
      if ((&y[63:47]) || !(|y[63:47])) begin
         round_q16 = y[47:16];
      end else begin
         round_q16 = y[63] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
      end
   endfunction

endpackage

@@ rtl/mvma_if.sv @@
interface mvma_req_if import mvma_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [IDX_W-1:0]         row;
   logic [IDX_W-1:0]         col;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, op, row, col, value, input ready);
   modport sink   (input valid, op, row, col, value, output ready);
endinterface

interface mvma_rsp_if import mvma_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         out_row;
   logic signed [DATA_W-1:0] result;
   logic                     last;

   modport source (output valid, out_row, result, last, input ready);
   modport sink   (input valid, out_row, result, last, output ready);
endinterface

@@ rtl/matrix_vector_multiply_accumulate.sv @@
// general matrix-vector multiply, c := beta*c + alpha*op(A)*b, signed q16.16.
// loads (A element, b element, prior c element) take one beat each, one load a
// cycle while idle. a compute beat walks the stored matrix one element a cycle
// out of a single synchronous matrix memory: the accept beat, then per row nk
// reads through the multiply-accumulate pipe, a drain until that pipe is empty,
// the three-stage scale pipe and an emit that waits for the result register to
// be free. each result is written back into c, and the final result of a
// compute has last set. the input side takes no beat while a compute runs; the
// result register lets the block go back to accepting loads while the final
// result is still waiting. no clearing pass after reset.
module matrix_vector_multiply_accumulate import mvma_pkg::*; #(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  logic                  clock,
   input  logic                  reset,
   mvma_req_if.sink              req,
   mvma_rsp_if.source            rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0]     pwdata,
   output logic [DATA_W-1:0]     prdata,
   output logic                  pready
);

   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_LIM0 = (MAX_ROWS < RESULT_LIMIT) ? MAX_ROWS : RESULT_LIMIT;
   localparam int ROW_LIM_T = (ROW_LIM0 < MAX_COLS) ? ROW_LIM0 : MAX_COLS;
   localparam int COL_LIM_T = (MAX_COLS < MAX_ROWS) ? MAX_COLS : MAX_ROWS;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DOT   = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_SCALE = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   // configuration registers
   logic signed [DATA_W-1:0] alpha_ff, beta_ff;
   logic [CNT_W-1:0]         num_rows_ff, num_cols_ff;
   logic                     transpose_ff;
   logic                     csr_write;
   logic [2:0]               csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= ALPHA_RESET;
         beta_ff      <= '0;
         num_rows_ff  <= CNT_W'(RESULT_LIMIT);
         num_cols_ff  <= CNT_W'(RESULT_LIMIT);
         transpose_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_ALPHA:     alpha_ff     <= pwdata;
            REG_BETA:      beta_ff      <= pwdata;
            REG_NUM_ROWS:  num_rows_ff  <= pwdata[CNT_W-1:0];
            REG_NUM_COLS:  num_cols_ff  <= pwdata[CNT_W-1:0];
            REG_TRANSPOSE: transpose_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ALPHA:     prdata = alpha_ff;
         REG_BETA:      prdata = beta_ff;
         REG_NUM_ROWS:  prdata = DATA_W'(num_rows_ff);
         REG_NUM_COLS:  prdata = DATA_W'(num_cols_ff);
         REG_TRANSPOSE: prdata = DATA_W'(transpose_ff);
         default:       prdata = '0;
      endcase
   end

   // effective counts: zero acts as one, clamp to what the stores hold
   logic [10:0]      row_lim, col_lim;
   logic [CNT_W-1:0] nr, nk;

   always_comb begin
      row_lim = transpose_ff ? 11'(ROW_LIM_T) : 11'(ROW_LIM0);
      col_lim = transpose_ff ? 11'(COL_LIM_T) : 11'(MAX_COLS);
      if (num_rows_ff == '0)                  nr = CNT_W'(1);
      else if (11'(num_rows_ff) > row_lim)    nr = CNT_W'(row_lim);
      else                                    nr = num_rows_ff;
      if (num_cols_ff == '0)                  nk = CNT_W'(1);
      else if (11'(num_cols_ff) > col_lim)    nk = CNT_W'(col_lim);
      else                                    nk = num_cols_ff;
   end

   // sequencer
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             mac_busy, mac_clear, mac_issue;
   logic             scale_start, scale_done;
   logic             rsp_free, emit;
   logic             is_last_row;

   assign rsp_free    = !rsp.valid || rsp.ready;
   assign is_last_row = (CNT_W'(i_ff) == nr - CNT_W'(1));
   assign req.ready   = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      k_in        = k_ff;
      mac_issue   = 1'b0;
      mac_clear   = 1'b0;
      scale_start = 1'b0;
      emit        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && op_type'(req.op) == OP_COMPUTE) begin
               i_in      = '0;
               k_in      = '0;
               mac_clear = 1'b1;
               state_in  = ST_DOT;
            end
         end
         ST_DOT: begin
            mac_issue = 1'b1;
            if (k_ff == nk - CNT_W'(1)) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            // prior c is read every cycle in every state, so it is ready here
            if (!mac_busy) begin
               scale_start = 1'b1;
               state_in    = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (scale_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               emit = 1'b1;
               if (is_last_row) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in      = i_ff + IDX_W'(1);
                  k_in      = '0;
                  mac_clear = 1'b1;
                  state_in  = ST_DOT;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         k_ff     <= k_in;
      end
   end

   // load decode
   logic       load_beat;
   logic       row_ok, col_ok;
   logic       wr_matrix, wr_vector, wr_prior_load;

   assign load_beat     = req.valid && req.ready;
   assign row_ok        = (11'(req.row) < 11'(MAX_ROWS));
   assign col_ok        = (11'(req.col) < 11'(MAX_COLS));
   assign wr_matrix     = load_beat && op_type'(req.op) == OP_LOAD_MATRIX && row_ok && col_ok;
   assign wr_vector     = load_beat && op_type'(req.op) == OP_LOAD_VECTOR && col_ok;
   assign wr_prior_load = load_beat && op_type'(req.op) == OP_LOAD_PRIOR && row_ok;

   // matrix memory, addressed {row, col}
   logic signed [DATA_W-1:0] matrix_mem [2**(RW+CW)];
   logic signed [DATA_W-1:0] matrix_rd_ff;
   logic [RW-1:0]            mrow;
   logic [CW-1:0]            mcol;

   assign mrow = transpose_ff ? RW'(k_ff) : RW'(i_ff);
   assign mcol = transpose_ff ? CW'(i_ff) : CW'(k_ff);

   always_ff @(posedge clock) begin
      if (wr_matrix) begin
         matrix_mem[{RW'(req.row), CW'(req.col)}] <= req.value;
      end
      matrix_rd_ff <= matrix_mem[{mrow, mcol}];
   end

   // vector memory
   logic signed [DATA_W-1:0] vector_mem [MAX_COLS];
   logic signed [DATA_W-1:0] vector_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_vector) begin
         vector_mem[CW'(req.col)] <= req.value;
      end
      vector_rd_ff <= vector_mem[CW'(k_ff)];
   end

   // prior result memory: loads in idle, write-back on emit, never together
   logic signed [DATA_W-1:0] prior_mem [MAX_ROWS];
   logic signed [DATA_W-1:0] prior_rd_ff;
   logic signed [DATA_W-1:0] scale_result;
   logic [RW-1:0]            prior_waddr;
   logic signed [DATA_W-1:0] prior_wdata;

   assign prior_waddr = emit ? RW'(i_ff) : RW'(req.row);
   assign prior_wdata = emit ? scale_result : req.value;

   always_ff @(posedge clock) begin
      if (emit || wr_prior_load) begin
         prior_mem[prior_waddr] <= prior_wdata;
      end
      prior_rd_ff <= prior_mem[RW'(i_ff)];
   end

   logic signed [ACC_W-1:0] dot;
   scale_cfg_type           scale_cfg;

   assign scale_cfg.alpha = alpha_ff;
   assign scale_cfg.beta  = beta_ff;

   mvma_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .issue  (mac_issue),
      .clear  (mac_clear),
      .a_data (matrix_rd_ff),
      .b_data (vector_rd_ff),
      .busy   (mac_busy),
      .dot    (dot)
   );

   mvma_scale u_scale (
      .clock  (clock),
      .reset  (reset),
      .start  (scale_start),
      .dot    (dot),
      .c_data (prior_rd_ff),
      .cfg    (scale_cfg),
      .done   (scale_done),
      .result (scale_result)
   );

   // result register
   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rsp_row_ff;
   logic signed [DATA_W-1:0] rsp_result_ff;
   logic                     rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_row_ff    <= i_ff;
         rsp_result_ff <= scale_result;
         rsp_last_ff   <= is_last_row;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.out_row = rsp_row_ff;
   assign rsp.result  = rsp_result_ff;
   assign rsp.last    = rsp_last_ff;

   // checks
   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DOT |-> k_ff < nk)
      else $error("dot index past column count");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> CNT_W'(i_ff) < nr)
      else $error("row index past row count");

   a_scale_after_drain: assert property (@(posedge clock) disable iff (reset)
      scale_start |-> !mac_busy && !$past(mac_issue))
      else $error("scale started with products in flight");

   a_emit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> !rsp_valid_ff || rsp.ready)
      else $error("result overwritten before taken");

endmodule

@@ rtl/mvma_mac.sv @@
module mvma_mac import mvma_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     issue,
   input  logic                     clear,
   input  logic signed [DATA_W-1:0] a_data,
   input  logic signed [DATA_W-1:0] b_data,
   output logic                     busy,
   output logic signed [ACC_W-1:0]  dot
);

   logic                    data_valid_ff;
   logic                    prod_valid_ff;
   logic signed [ACC_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] dot_ff;
   logic signed [ACC_W-1:0] dot_in;

   // memory data arrives in the cycle after the read is issued
   always_ff @(posedge clock) begin
      if (reset) begin
         data_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         data_valid_ff <= issue;
         prod_valid_ff <= data_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (data_valid_ff) begin
         prod_ff <= a_data * b_data;
      end
   end

   always_comb begin
      dot_in = dot_ff;
      if (clear) begin
         dot_in = '0;
      end else if (prod_valid_ff) begin
         dot_in = sat_add64(dot_ff, prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff <= '0;
      end else begin
         dot_ff <= dot_in;
      end
   end

   assign busy = data_valid_ff | prod_valid_ff;
   assign dot  = dot_ff;

endmodule

@@ rtl/mvma_scale.sv @@
module mvma_scale import mvma_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [ACC_W-1:0]  dot,
   input  logic signed [DATA_W-1:0] c_data,
   input  scale_cfg_type            cfg,
   output logic                     done,
   output logic signed [DATA_W-1:0] result
);

   logic                     v0_ff, v1_ff, v2_ff;
   logic signed [DATA_W-1:0] d_ff, c_ff;
   logic signed [ACC_W-1:0]  t1_ff, t2_ff;
   logic signed [DATA_W-1:0] res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= start;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         d_ff <= round_q16(dot);
         // beta of zero means prior c is not used
         c_ff <= (cfg.beta != '0) ? c_data : '0;
      end
      if (v0_ff) begin
         t1_ff <= cfg.beta * c_ff;
         t2_ff <= cfg.alpha * d_ff;
      end
      if (v1_ff) begin
         res_ff <= round_q16(sat_add64(t1_ff, t2_ff));
      end
   end

   assign done   = v2_ff;
   assign result = res_ff;

endmodule

@@ dv/mvma_result_check.sv @@
module mvma_result_check import mvma_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mvma_req_if                   req,
   mvma_rsp_if                   rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0]     pwdata,
   input  logic                  pready,
   output int                    errors,
   output int                    pending
);

   typedef struct {
      logic [IDX_W-1:0]         out_row;
      logic signed [DATA_W-1:0] result;
      logic                     last;
   } row_result_type;

   row_result_type expected_rows[$];

   logic signed [DATA_W-1:0] mat_a [64][64];
   logic signed [DATA_W-1:0] vec_b [64];
   logic signed [DATA_W-1:0] vec_c [64];
   logic signed [DATA_W-1:0] alpha_q, beta_q;
   logic [CNT_W-1:0]         rows_cfg, cols_cfg;
   logic                     tr_cfg;

   function automatic logic signed [63:0] add_clip(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      return s[63:0];
   endfunction

   // q32.32 down to q16.16, half up, clipped to 32 bits
   function automatic logic signed [31:0] to_q16(input logic signed [63:0] x);
      logic signed [63:0] q;
      q = add_clip(x, 64'sd32768) >>> 16;
      if (q > 64'sd2147483647) return 32'sh7fffffff;
      if (q < -64'sd2147483648) return 32'sh80000000;
      return q[31:0];
   endfunction

   function automatic int clip_count(input logic [CNT_W-1:0] n);
      if (n == 0) return 1;
      return (n > 64) ? 64 : int'(n);
   endfunction

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
   endtask

   task automatic predict_compute();
      int nr, nk;
      logic signed [63:0] dot, term1, term2;
      logic signed [31:0] d, res;
      row_result_type r;
      nr = clip_count(rows_cfg);
      nk = clip_count(cols_cfg);
      for (int i = 0; i < nr; i++) begin
         dot = 0;
         for (int k = 0; k < nk; k++) begin
            dot = add_clip(dot, (tr_cfg ? mat_a[k][i] : mat_a[i][k]) * 64'(vec_b[k]));
         end
         d = to_q16(dot);
         term1 = (beta_q != 0) ? beta_q * 64'(vec_c[i]) : 64'sd0;
         term2 = (alpha_q != 0) ? alpha_q * 64'(d) : 64'sd0;
         res = to_q16(add_clip(term1, term2));
         vec_c[i] = res;
         r.out_row = i[IDX_W-1:0];
         r.result = res;
         r.last = (i + 1 == nr);
         expected_rows.push_back(r);
      end
   endtask

   initial begin
      errors = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         alpha_q <= ALPHA_RESET;
         beta_q <= 0;
         rows_cfg <= 64;
         cols_cfg <= 64;
         tr_cfg <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_ALPHA:     alpha_q = pwdata;
               REG_BETA:      beta_q = pwdata;
               REG_NUM_ROWS:  rows_cfg = pwdata[CNT_W-1:0];
               REG_NUM_COLS:  cols_cfg = pwdata[CNT_W-1:0];
               REG_TRANSPOSE: tr_cfg = pwdata[0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            case (op_type'(req.op))
               OP_LOAD_MATRIX: mat_a[req.row][req.col] = req.value;
               OP_LOAD_VECTOR: vec_b[req.col] = req.value;
               OP_LOAD_PRIOR:  vec_c[req.row] = req.value;
               OP_COMPUTE:     predict_compute();
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_rows.size() == 0) begin
               report($sformatf("unexpected result row %0d", rsp.out_row));
            end else begin
               row_result_type e;
               e = expected_rows.pop_front();
               if (rsp.out_row !== e.out_row)
                  report($sformatf("out_row %0d, want %0d", rsp.out_row, e.out_row));
               if (rsp.result !== e.result)
                  report($sformatf("row %0d result %h, want %h", e.out_row, rsp.result,
                                   e.result));
               if (rsp.last !== e.last)
                  report($sformatf("row %0d last %b, want %b", e.out_row, rsp.last, e.last));
            end
         end
      end
      pending = expected_rows.size();
   end

endmodule

@@ dv/tb_matrix_vector_multiply_accumulate.sv @@
module tb_matrix_vector_multiply_accumulate;
   import mvma_pkg::*;

   // write to an address past the register list, must be ignored
   localparam logic [2:0] REG_SPARE = 3'd5;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [DATA_W-1:0]     pwdata;
   logic [DATA_W-1:0]     prdata;
   logic                  pready;
   int                    errors, pending;

   mvma_req_if req();
   mvma_rsp_if rsp();

   matrix_vector_multiply_accumulate i_dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   mvma_result_check i_check (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
   );

   always #10 clock = ~clock;

   // hard stop far beyond the slowest legal run
   initial begin
      #200000000;
      $display("tb: failure");
      $finish;
   end

   // which store entries hold data, so no compute reads an unwritten one
   bit a_written [64][64];
   bit b_written [64];
   bit c_written [64];

   // local copy of beta and the sizing registers
   logic signed [31:0] beta_now;
   logic [6:0]         rows_now, cols_now;
   logic               tr_now;

   int  beats;       // beats accepted so far
   bit  calm;        // no idling in the closing stretch
   bit  hold_long;   // ask the receiver for one long hold-off

   // receiver side: random stall bursts, one long hold on request
   initial begin
      rsp.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_long) begin
            hold_long = 0;
            rsp.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (calm || $urandom_range(0, 3) == 0) begin
            rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end else begin
            rsp.ready <= $urandom_range(0, 1);
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
      end
   end

   function automatic int clip_count(input logic [6:0] n);
      if (n == 0) return 1;
      return (n > 64) ? 64 : int'(n);
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom();
         default: return $signed($urandom_range(0, 393216)) - 196608;
      endcase
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_BETA:      beta_now = data;
         REG_NUM_ROWS:  rows_now = data[6:0];
         REG_NUM_COLS:  cols_now = data[6:0];
         REG_TRANSPOSE: tr_now = data[0];
         default: ;
      endcase
   endtask

   // one beat on the request channel, valid stays up for back-to-back beats
   task automatic send(input op_type op, input logic [5:0] r, input logic [5:0] c,
                       input logic signed [31:0] v);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.op <= op;
      req.row <= r;
      req.col <= c;
      req.value <= v;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      beats++;
      case (op)
         OP_LOAD_MATRIX: a_written[r][c] = 1;
         OP_LOAD_VECTOR: b_written[c] = 1;
         OP_LOAD_PRIOR:  c_written[r] = 1;
         default: ;
      endcase
   endtask

   // wait until every result is back, then let the pipe drain
   task automatic settle();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic setup(input logic [31:0] al, input logic [31:0] be, input logic [6:0] nr,
                        input logic [6:0] nk, input logic tr);
      settle();
      csr_write(REG_ALPHA, al);
      csr_write(REG_BETA, be);
      csr_write(REG_NUM_ROWS, {25'($urandom), nr});
      csr_write(REG_NUM_COLS, {25'($urandom), nk});
      csr_write(REG_TRANSPOSE, {31'($urandom), tr});
   endtask

   // load whatever the compute will read and is still missing, then compute
   task automatic compute();
      int nr, nk;
      nr = clip_count(rows_now);
      nk = clip_count(cols_now);
      for (int i = 0; i < nr; i++) begin
         for (int k = 0; k < nk; k++) begin
            if (tr_now && !a_written[k][i])
               send(OP_LOAD_MATRIX, 6'(k), 6'(i), pick_value());
            if (!tr_now && !a_written[i][k])
               send(OP_LOAD_MATRIX, 6'(i), 6'(k), pick_value());
         end
      end
      for (int k = 0; k < nk; k++) begin
         if (!b_written[k]) send(OP_LOAD_VECTOR, 6'($urandom), 6'(k), pick_value());
      end
      if (beta_now != 0) begin
         for (int i = 0; i < nr; i++) begin
            if (!c_written[i]) send(OP_LOAD_PRIOR, 6'(i), 6'($urandom), pick_value());
         end
      end
      // row, col and value are don't-care on a compute beat
      send(OP_COMPUTE, 6'($urandom), 6'($urandom), $urandom);
      for (int i = 0; i < nr; i++) c_written[i] = 1;
   endtask

   task automatic random_loads(input int n);
      logic [5:0] r, c;
      repeat (n) begin
         r = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
         c = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
         send(op_type'($urandom_range(0, 2)), r, c, pick_value());
      end
   endtask

   function automatic logic [31:0] pick_scale();
      case ($urandom_range(0, 6))
         0: return 0;
         1: return 32'h00010000;
         2: return 32'h7fffffff;
         3: return 32'h80000000;
         4: return $urandom();
         default: return $signed($urandom_range(0, 262144)) - 131072;
      endcase
   endfunction

   initial begin
      int phase;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req.valid = 1'b0;
      req.op = OP_LOAD_MATRIX;
      req.row = '0;
      req.col = '0;
      req.value = '0;
      beats = 0;
      calm = 0;
      hold_long = 0;
      beta_now = 0;
      rows_now = 64;
      cols_now = 64;
      tr_now = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: accumulator clipping, most negative values everywhere
      setup(32'h00010000, 0, 1, 4, 0);
      for (int k = 0; k < 4; k++) send(OP_LOAD_MATRIX, 0, 6'(k), 32'sh80000000);
      for (int k = 0; k < 4; k++) send(OP_LOAD_VECTOR, 0, 6'(k), 32'sh80000000);
      compute();
      // largest positive values, negative beta against prior result
      setup(32'h7fffffff, 32'h80000000, 2, 2, 0);
      send(OP_LOAD_MATRIX, 1, 0, 32'sh7fffffff);
      send(OP_LOAD_PRIOR, 0, 63, 32'sh7fffffff);
      send(OP_LOAD_PRIOR, 63, 0, 32'sh80000000);
      compute();
      // zero alpha keeps only the scaled prior result, spare address is ignored
      setup(0, 32'h00018000, 2, 2, 1);
      csr_write(REG_SPARE, $urandom);
      compute();
      // zero counts act as one
      setup(32'hffff0000, 0, 0, 0, 0);
      compute();

      // random phases, a few with the widest shapes
      phase = 0;
      while (beats < 320) begin
         if (beats > 270) calm = 1;
         case (phase)
            3: setup(pick_scale(), pick_scale(), 127, 0, 1);   // 64 rows, transposed
            6: setup(pick_scale(), pick_scale(), 0, 127, 0);   // one row of 64
            9: setup(pick_scale(), pick_scale(), 64, 1, 0);
            default: setup(pick_scale(), pick_scale(), 7'($urandom_range(1, 6)),
                           7'($urandom_range(1, 6)), 1'($urandom_range(0, 1)));
         endcase
         repeat ($urandom_range(2, 4)) begin
            random_loads($urandom_range(0, 6));
            if (phase == 3) hold_long = 1;
            compute();
            // keep offering beats while the results back up
            if (phase == 3) random_loads(6);
         end
         phase++;
      end

      settle();
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/mvma_pkg.sv
rtl/mvma_if.sv
rtl/mvma_mac.sv
rtl/mvma_scale.sv
rtl/matrix_vector_multiply_accumulate.sv
dv/mvma_result_check.sv
dv/tb_matrix_vector_multiply_accumulate.sv
